// ===== design/pdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse decoder package
// Shared types and constants for the LED chain pulse decoder.
// ----------------------------------------------------------------------------
package pdec_pkg;

	localparam int DEF_MAX_WIDTH  = 16;
	localparam int DEF_MAX_HEIGHT = 16;

	localparam int BITS_PER_LED = 24;
	localparam int TIME_W       = 15;
	localparam int DIM_W        = 5;
	localparam int COLOR_W      = 8;
	localparam int INDEX_W      = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LATCH_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0]  RST_CHAIN_WIDTH     = 5'd16;
	localparam logic [DIM_W-1:0]  RST_CHAIN_HEIGHT    = 5'd16;
	localparam logic [TIME_W-1:0] RST_LATCH_THRESHOLD = 15'd17;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_LOAD,
		ST_DIV
	} pdec_state_t;

	typedef struct packed {
		logic item_go;
		logic div_load;
		logic div_step;
		logic div_last;
	} pdec_cmd_t;

	typedef struct packed {
		logic queue_full;
	} pdec_status_t;

	typedef struct packed {
		logic               pixel_write;
		logic [INDEX_W-1:0] pixel_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               frame_end;
	} pdec_result_t;

endpackage

// ===== design/pdec_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse decoder controller
// Sequences item acceptance and the position recompute after config writes.
// ----------------------------------------------------------------------------
module pdec_ctrl #(
	parameter int DIV_STEPS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  cfg_we,
	input  pdec_pkg::pdec_status_t status,
	output logic                  in_ready,
	output pdec_pkg::pdec_cmd_t    cmd
);

	localparam int SCW = $clog2(DIV_STEPS + 1);

	pdec_pkg::pdec_state_t state_q, state_d;
	logic [SCW-1:0]        step_q;
	logic                  step_last;

	assign step_last = (step_q == SCW'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdec_pkg::ST_RUN;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pdec_pkg::ST_DIV) begin
				step_q <= step_q + SCW'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdec_pkg::ST_RUN: begin
				if (cfg_we) state_d = pdec_pkg::ST_LOAD;
			end
			pdec_pkg::ST_LOAD: begin
				state_d = cfg_we ? pdec_pkg::ST_LOAD : pdec_pkg::ST_DIV;
			end
			pdec_pkg::ST_DIV: begin
				if (cfg_we) state_d = pdec_pkg::ST_LOAD;
				else if (step_last) state_d = pdec_pkg::ST_RUN;
			end
			default: state_d = pdec_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == pdec_pkg::ST_RUN) && !status.queue_full;
		cmd.item_go  = in_ready && in_valid;
		cmd.div_load = (state_q == pdec_pkg::ST_LOAD);
		cmd.div_step = (state_q == pdec_pkg::ST_DIV);
		cmd.div_last = (state_q == pdec_pkg::ST_DIV) && step_last;
	end

`ifndef SYNTH
	a_no_item_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !cmd.item_go)
		else $error("Item accepted right after a configuration write.");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_last |=> (state_q == pdec_pkg::ST_RUN || state_q == pdec_pkg::ST_LOAD))
		else $error("Recompute did not finish after its last step.");

	a_load_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_load && !cfg_we) |=> (cmd.div_step && step_q == '0))
		else $error("Recompute did not start from its first step.");
`endif

endmodule

// ===== design/pdec_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse decoder datapath
// Config registers, bit and LED counters, panel position and its divider.
// ----------------------------------------------------------------------------
module pdec_dpath #(
	parameter int MAX_WIDTH  = pdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pdec_pkg::pdec_cmd_t                 cmd,
	input  logic                                cfg_we,
	input  logic [pdec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdec_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [pdec_pkg::TIME_W-1:0]         high_time,
	input  logic [pdec_pkg::TIME_W-1:0]         low_time,
	output logic                                res_valid,
	output pdec_pkg::pdec_result_t              res
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int LCW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SWW = pdec_pkg::BITS_PER_LED;

	logic [pdec_pkg::DIM_W-1:0]  width_q;
	logic [pdec_pkg::DIM_W-1:0]  height_q;
	logic [pdec_pkg::TIME_W-1:0] thr_q;

	logic [SWW-1:0] shift_q;
	logic [4:0]     bit_cnt_q;
	logic [LCW-1:0] led_cnt_q;
	logic [WW-1:0]  x_q;
	logic [HW-1:0]  y_q;
	logic [WW-1:0]  rem_q;
	logic [LCW-1:0] quo_q;

	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [LCW-1:0]   npix;
	logic [SWW-1:0]   shift_n;
	logic             word_done;
	logic             wr;
	logic             fe;
	logic             x_last;
	logic [WW-1:0]    x_map;
	logic [LCW-1:0]   idx;
	logic [LCW+7:0]   idx_ext;
	logic [WW:0]      rem_sh;
	logic [WW:0]      w_ext;
	logic             ge;
	logic [WW:0]      rem_d;
	logic [LCW:0]     quo_n;

	always_comb begin
		if (width_q == '0) w_eff = WW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		if (height_q == '0) h_eff = HW'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
	end

	assign npix = LCW'(w_eff) * LCW'(h_eff);

	always_comb begin
		shift_n   = {shift_q[SWW-2:0], (high_time > low_time)};
		word_done = (bit_cnt_q == 5'(SWW - 1));
		wr        = word_done && (led_cnt_q < npix);
		fe        = (low_time > thr_q);
		x_last    = (x_q == w_eff - WW'(1));
		x_map     = y_q[0] ? x_q : (w_eff - WW'(1) - x_q);
		idx       = LCW'(x_map) + LCW'(y_q) * LCW'(w_eff);
		idx_ext   = {8'b0, idx};

		res_valid       = cmd.item_go && (wr || fe);
		res.pixel_write = wr;
		res.pixel_index = wr ? idx_ext[7:0] : 8'd0;
		res.green       = wr ? shift_n[23:16] : 8'd0;
		res.red         = wr ? shift_n[15:8] : 8'd0;
		res.blue        = wr ? shift_n[7:0] : 8'd0;
		res.frame_end   = fe;
	end

	always_comb begin
		rem_sh = {rem_q, quo_q[LCW-1]};
		w_ext  = {1'b0, w_eff};
		ge     = (rem_sh >= w_ext);
		rem_d  = ge ? (rem_sh - w_ext) : rem_sh;
		quo_n  = {quo_q, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pdec_pkg::RST_CHAIN_WIDTH;
			height_q <= pdec_pkg::RST_CHAIN_HEIGHT;
			thr_q    <= pdec_pkg::RST_LATCH_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				pdec_pkg::CFG_CHAIN_WIDTH:     width_q  <= cfg_data[pdec_pkg::DIM_W-1:0];
				pdec_pkg::CFG_CHAIN_HEIGHT:    height_q <= cfg_data[pdec_pkg::DIM_W-1:0];
				pdec_pkg::CFG_LATCH_THRESHOLD: thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			bit_cnt_q <= '0;
			led_cnt_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
		end else if (cmd.item_go) begin
			shift_q   <= shift_n;
			bit_cnt_q <= (fe || word_done) ? 5'd0 : bit_cnt_q + 5'd1;
			if (fe) begin
				led_cnt_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
			end else if (wr) begin
				led_cnt_q <= led_cnt_q + LCW'(1);
				if (x_last) begin
					x_q <= '0;
					y_q <= y_q + HW'(1);
				end else begin
					x_q <= x_q + WW'(1);
				end
			end else if (word_done) begin
				led_cnt_q <= npix;
				x_q       <= '0;
				y_q       <= h_eff;
			end
		end else if (cmd.div_last) begin
			x_q <= rem_d[WW-1:0];
			y_q <= quo_n[HW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= led_cnt_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_d[WW-1:0];
			quo_q <= quo_n[LCW-1:0];
		end
	end

endmodule

// ===== design/pdec_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse decoder result buffer
// Two-entry buffer between the datapath and the result channel.
// ----------------------------------------------------------------------------
module pdec_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pdec_pkg::pdec_result_t push_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output pdec_pkg::pdec_result_t head,
	output pdec_pkg::pdec_status_t status
);

	logic [1:0]             cnt_q;
	pdec_pkg::pdec_result_t head_q;
	pdec_pkg::pdec_result_t tail_q;
	logic                   pop;

	assign out_valid         = (cnt_q != 2'd0);
	assign pop               = out_valid && out_ready;
	assign head              = head_q;
	assign status.queue_full = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) head_q <= tail_q;
			else if (push) head_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0) head_q <= push_data;
			else tail_q <= push_data;
		end
	end

endmodule

// ===== design/led_chain_pulse_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain pulse decoder
// Turns measured pulses into colour words for a serpentine LED panel.
// ----------------------------------------------------------------------------
// Channel   Handshake            Beat contents
// config    cfg_we               cfg_index, cfg_data
// input     in_valid / in_ready  high_time, low_time
// result    out_valid / out_ready pixel_write, pixel_index, red, green, blue,
//                                frame_end
//
// One pulse beat is taken per cycle while in_ready is high; each result is
// registered in the result buffer before it is offered. Each configuration
// write starts a recompute of the panel column and row from the LED count
// by a restoring divider, one bit a cycle: in_ready is low until the
// recompute after the last write ends. A two-entry result buffer keeps input
// flowing while one result waits; in_ready also drops when both are held.
// Reset clears the counters and restores the register defaults.
// ----------------------------------------------------------------------------
module led_chain_pulse_decoder_core #(
	parameter int MAX_WIDTH  = pdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdec_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pdec_pkg::TIME_W-1:0]     high_time,
	input  logic [pdec_pkg::TIME_W-1:0]     low_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            pixel_write,
	output logic [pdec_pkg::INDEX_W-1:0]    pixel_index,
	output logic [pdec_pkg::COLOR_W-1:0]    red,
	output logic [pdec_pkg::COLOR_W-1:0]    green,
	output logic [pdec_pkg::COLOR_W-1:0]    blue,
	output logic                            frame_end
);

	localparam int DIV_STEPS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	pdec_pkg::pdec_cmd_t    cmd;
	pdec_pkg::pdec_status_t status;
	pdec_pkg::pdec_result_t res;
	pdec_pkg::pdec_result_t head;
	logic                   res_valid;

	pdec_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_we   (cfg_we),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	pdec_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.high_time (high_time),
		.low_time  (low_time),
		.res_valid (res_valid),
		.res       (res)
	);

	pdec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.status    (status)
	);

	assign pixel_write = head.pixel_write;
	assign pixel_index = head.pixel_index;
	assign red         = head.red;
	assign green       = head.green;
	assign blue        = head.blue;
	assign frame_end   = head.frame_end;

endmodule

// ===== sim/led_chain_pulse_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain pulse decoder testbench
// Sends measured pulses, mostly as well-formed 24-bit colour words and
// frames with random content, across a series of panel sizes and latch
// thresholds. A local pixel predictor works out each expected pixel write
// and frame end, and a checker compares every result beat in order.
// ----------------------------------------------------------------------------
module led_chain_pulse_decoder_core_tb;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RAND_ITEMS  = 950;
	localparam logic [pdec_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pdec_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pdec_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [pdec_pkg::TIME_W-1:0]     high_time;
	logic [pdec_pkg::TIME_W-1:0]     low_time;
	logic                            out_valid;
	logic                            out_ready;
	logic                            pixel_write;
	logic [pdec_pkg::INDEX_W-1:0]    pixel_index;
	logic [pdec_pkg::COLOR_W-1:0]    red;
	logic [pdec_pkg::COLOR_W-1:0]    green;
	logic [pdec_pkg::COLOR_W-1:0]    blue;
	logic                            frame_end;

	led_chain_pulse_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.high_time   (high_time),
		.low_time    (low_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_write (pixel_write),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end)
	);

	// Predictor copy of the block state and registers.
	logic [23:0]                 pix_word;
	int unsigned                 pix_bits;
	int unsigned                 led_total;
	logic [pdec_pkg::DIM_W-1:0]  cfg_w;
	logic [pdec_pkg::DIM_W-1:0]  cfg_h;
	logic [pdec_pkg::TIME_W-1:0] cfg_thr;

	pdec_pkg::pdec_result_t expected_px[$];

	int n_items;
	int n_errors;
	int n_writes;
	int n_latches;
	int n_cfg;
	int cycles;
	int recv_hold;
	bit send_idle;
	bit recv_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				expected_px.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int unsigned dim_eff(logic [pdec_pkg::DIM_W-1:0] v,
			int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic string fmt_px(pdec_pkg::pdec_result_t r);
		return $sformatf("wr=%0b idx=%0d r=%02h g=%02h b=%02h fe=%0b", r.pixel_write,
			r.pixel_index, r.red, r.green, r.blue, r.frame_end);
	endfunction

	function automatic void note_error(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("ERROR at cycle %0d: %s", cycles, msg);
	endfunction

	function automatic void predict_pulse(logic [pdec_pkg::TIME_W-1:0] hi,
			logic [pdec_pkg::TIME_W-1:0] lo);
		int unsigned            w;
		int unsigned            h;
		int unsigned            npix;
		int unsigned            x;
		int unsigned            y;
		int unsigned            idx;
		pdec_pkg::pdec_result_t r;
		w = dim_eff(cfg_w, pdec_pkg::DEF_MAX_WIDTH);
		h = dim_eff(cfg_h, pdec_pkg::DEF_MAX_HEIGHT);
		npix = w * h;
		r = '0;
		pix_word = {pix_word[22:0], hi > lo};
		pix_bits++;
		if (pix_bits >= pdec_pkg::BITS_PER_LED) begin
			pix_bits = 0;
			if (led_total < npix) begin
				x = led_total % w;
				y = led_total / w;
				if (y % 2 == 0)
					x = w - 1 - x;
				idx = x + y * w;
				r.pixel_write = 1'b1;
				r.pixel_index = idx[pdec_pkg::INDEX_W-1:0];
				r.green = pix_word[23:16];
				r.red = pix_word[15:8];
				r.blue = pix_word[7:0];
				led_total++;
			end else begin
				led_total = npix;
			end
		end
		if (lo > cfg_thr) begin
			pix_bits = 0;
			led_total = 0;
			r.frame_end = 1'b1;
		end
		if (r.pixel_write || r.frame_end)
			expected_px.push_back(r);
	endfunction

	function automatic void check_result(pdec_pkg::pdec_result_t got);
		pdec_pkg::pdec_result_t want;
		if (expected_px.size() == 0) begin
			note_error($sformatf("unexpected result %s", fmt_px(got)));
			return;
		end
		want = expected_px.pop_front();
		if (got.pixel_write !== want.pixel_write || got.pixel_index !== want.pixel_index ||
				got.red !== want.red || got.green !== want.green ||
				got.blue !== want.blue || got.frame_end !== want.frame_end)
			note_error($sformatf("expected %s, got %s", fmt_px(want), fmt_px(got)));
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_result({pixel_write, pixel_index, red, green, blue, frame_end});
			if (pixel_write)
				n_writes++;
			if (frame_end)
				n_latches++;
		end
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				repeat (recv_hold) @(posedge clk);
				recv_hold = 0;
			end
			gap = recv_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pulse(input logic [pdec_pkg::TIME_W-1:0] hi,
			input logic [pdec_pkg::TIME_W-1:0] lo);
		int gap;
		gap = send_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		high_time <= hi;
		low_time <= lo;
		do @(posedge clk); while (!in_ready);
		predict_pulse(hi, lo);
		n_items++;
	endtask

	// A latch is only possible while the threshold is below the top value.
	task automatic send_bit(input bit b, input bit latch);
		int unsigned hi;
		int unsigned lo;
		if (latch && cfg_thr < 15'h7fff)
			lo = $urandom_range(32767, int'(cfg_thr) + 1);
		else
			lo = $urandom_range(int'(cfg_thr), 0);
		if (lo == 32767)
			b = 1'b0;
		hi = b ? $urandom_range(32767, lo + 1) : $urandom_range(lo, 0);
		send_pulse(hi[pdec_pkg::TIME_W-1:0], lo[pdec_pkg::TIME_W-1:0]);
	endtask

	task automatic send_word(input logic [23:0] colour, input int cut, input bit latch_last);
		int i;
		for (i = 23; i >= 24 - cut; i--)
			send_bit(colour[i], latch_last && i == 24 - cut);
	endtask

	task automatic send_frame(input int words, input bit rough);
		int          k;
		int          cut;
		bit          latched;
		logic [23:0] colour;
		latched = 1'b0;
		for (k = 0; k < words; k++) begin
			colour = 24'($urandom);
			cut = (rough && $urandom_range(0, 11) == 0) ? $urandom_range(1, 23) : 24;
			latched = cut < 24 || (k == words - 1 && $urandom_range(0, 3) == 0);
			if (rough && $urandom_range(0, 15) == 0)
				send_pulse(15'($urandom), 15'($urandom));
			send_word(colour, cut, latched);
		end
		if (!latched)
			send_bit($urandom_range(0, 1), 1'b1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pdec_pkg::CFG_IDX_W-1:0] idx,
			input logic [pdec_pkg::CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pdec_pkg::CFG_CHAIN_WIDTH: cfg_w = data[pdec_pkg::DIM_W-1:0];
			pdec_pkg::CFG_CHAIN_HEIGHT: cfg_h = data[pdec_pkg::DIM_W-1:0];
			pdec_pkg::CFG_LATCH_THRESHOLD: cfg_thr = data;
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic test_pulse_extremes();
		send_pulse(15'd0, 15'd0);
		send_pulse(15'h7fff, 15'd0);
		send_pulse(15'h7fff, 15'd17);
		send_pulse(15'd18, 15'd17);
		send_pulse(15'd16, 15'd17);
		send_pulse(15'd0, 15'd18);
		send_pulse(15'h7fff, 15'h7fff);
		send_pulse(15'h7ffe, 15'h7fff);
		send_pulse(15'h5555, 15'h2aaa);
		send_pulse(15'h2aaa, 15'h5555);
	endtask

	task automatic test_single_led();
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'd1);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'd1);
		write_reg(pdec_pkg::CFG_LATCH_THRESHOLD, 15'd0);
		send_word(24'hffffff, 24, 1'b0);
		send_word(24'h000000, 24, 1'b0);
		send_bit(1'b1, 1'b1);
		send_word(24'h5a3cc3, 24, 1'b1);
		send_word(24'ha5c33c, 24, 1'b1);
	endtask

	task automatic test_dim_clamp();
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'd0);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'd0);
		write_reg(pdec_pkg::CFG_LATCH_THRESHOLD, 15'd17);
		send_frame(2, 1'b0);
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'h7ff3);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'h7fe2);
		write_reg(pdec_pkg::CFG_LATCH_THRESHOLD, 15'h7fff);
		write_reg(CFG_UNUSED, 15'h5555);
		send_frame(3, 1'b0);
	endtask

	task automatic test_serpentine();
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'd3);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'd3);
		write_reg(pdec_pkg::CFG_LATCH_THRESHOLD, 15'd17);
		send_bit(1'b0, 1'b1);
		send_frame(10, 1'b0);
	endtask

	task automatic test_shrink();
		int k;
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'd16);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'd16);
		for (k = 0; k < 5; k++)
			send_word(24'($urandom), 24, 1'b0);
		write_reg(pdec_pkg::CFG_CHAIN_WIDTH, 15'd2);
		write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, 15'd1);
		send_word(24'($urandom), 24, 1'b0);
		send_word(24'($urandom), 24, 1'b0);
		send_bit(1'b1, 1'b1);
		send_frame(3, 1'b0);
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle = 1'b0;
		recv_hold = 80;
		repeat (30) send_bit($urandom_range(0, 1), 1'b1);
		send_frame(3, 1'b0);
		send_idle = 1'b1;
	endtask

	function automatic logic [pdec_pkg::DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 5'd0;
			1: return 5'($urandom_range(17, 31));
			2: return 5'd16;
			default: return 5'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic test_random_frames();
		int                          start;
		int                          nf;
		int unsigned                 npix;
		logic [pdec_pkg::TIME_W-1:0] thr;
		start = n_items;
		while (n_items - start < RAND_ITEMS) begin
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 5))
				0: thr = 15'd0;
				1: thr = 15'h7fff;
				2: thr = 15'($urandom);
				default: thr = 15'($urandom_range(1, 200));
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(pdec_pkg::CFG_CHAIN_WIDTH, {10'($urandom), pick_dim()});
			if ($urandom_range(0, 3) != 0)
				write_reg(pdec_pkg::CFG_CHAIN_HEIGHT, {10'($urandom), pick_dim()});
			write_reg(pdec_pkg::CFG_LATCH_THRESHOLD, thr);
			npix = dim_eff(cfg_w, pdec_pkg::DEF_MAX_WIDTH) *
				dim_eff(cfg_h, pdec_pkg::DEF_MAX_HEIGHT);
			if ($urandom_range(0, 9) == 0) begin
				repeat (40) send_pulse(15'($urandom), 15'($urandom));
			end else begin
				nf = $urandom_range(1, 4);
				repeat (nf)
					send_frame(npix <= 16 ? $urandom_range(0, npix + 2) : $urandom_range(0, 4),
						1'b1);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= pdec_pkg::CFG_CHAIN_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		high_time <= '0;
		low_time <= '0;
		cycles = 0;
		recv_hold = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		pix_word = '0;
		pix_bits = 0;
		led_total = 0;
		cfg_w = pdec_pkg::RST_CHAIN_WIDTH;
		cfg_h = pdec_pkg::RST_CHAIN_HEIGHT;
		cfg_thr = pdec_pkg::RST_LATCH_THRESHOLD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pulse_extremes();
		test_single_led();
		test_dim_clamp();
		test_serpentine();
		test_shrink();
		test_backpressure();
		test_random_frames();

		in_valid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d pulses under %0d register writes.", n_items, n_cfg);
		$display("Checked %0d pixel writes and %0d frame ends, %0d mismatches.", n_writes,
			n_latches, n_errors);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
